// ===== sv/ggvc_pkg.sv =====
package ggvc_pkg;

  localparam int unsigned CORDIC_STAGES = 16;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned ANG_W      = 16;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned FRAC_SHIFT = 24;
  localparam int unsigned XY_W       = 60;
  localparam int unsigned Z_W        = 36;
  localparam int unsigned XS_W       = XY_W - FRAC_SHIFT;
  localparam int unsigned SPLIT      = 18;
  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned PLO_W      = SPLIT + 1 + GAIN_W;
  localparam int unsigned PHI_W      = XS_W - SPLIT + GAIN_W;
  localparam int unsigned PROD_W     = 68;
  localparam int unsigned SPD_SHIFT  = 34;
  localparam int unsigned TRN_SHIFT  = 19;
  localparam int unsigned HD_SHIFT   = 17;
  localparam int unsigned SAT_W      = 38;
  localparam int unsigned ATAN_W     = 30;

  localparam logic signed [Z_W-1:0]    PI_Q30     = 36'sd3373259426;
  localparam logic signed [Z_W-1:0]    TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [GAIN_W-1:0] SPEED_GAIN = 31'sd521626299;

  localparam logic [ATAN_W-1:0] ATAN_Q30 [0:31] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SPEED_MIN     = 2'd0;
  localparam cfg_idx_t CFG_SPEED_MAX     = 2'd1;
  localparam cfg_idx_t CFG_TURN_RATE_MIN = 2'd2;
  localparam cfg_idx_t CFG_TURN_RATE_MAX = 2'd3;

  localparam logic signed [CMD_W-1:0] SPEED_MIN_RST     = 16'sd0;
  localparam logic signed [CMD_W-1:0] SPEED_MAX_RST     = 16'sd4096;
  localparam logic signed [CMD_W-1:0] TURN_RATE_MIN_RST = -16'sd4096;
  localparam logic signed [CMD_W-1:0] TURN_RATE_MAX_RST = 16'sd4096;

  typedef struct packed {
    logic valid;
    logic present;
    logic zero;
  } ctl_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] speed_min;
    logic signed [CMD_W-1:0] speed_max;
    logic signed [CMD_W-1:0] turn_rate_min;
    logic signed [CMD_W-1:0] turn_rate_max;
  } cfg_t;

  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi_lim;
    logic signed [SAT_W-1:0] lo_lim;
    hi_lim = SAT_W'(32767);
    lo_lim = -SAT_W'(32768);
    if (v > hi_lim) begin
      return 16'sh7FFF;
    end else if (v < lo_lim) begin
      return 16'sh8000;
    end
    return v[CMD_W-1:0];
  endfunction

  // Raise to the lower limit first, then lower to the upper one
  function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [CMD_W-1:0] v,
                                                        input logic signed [CMD_W-1:0] lo,
                                                        input logic signed [CMD_W-1:0] hi);
    logic signed [CMD_W-1:0] r;
    r = v;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

// ===== sv/ggvc_in_if.sv =====
interface ggvc_in_if import ggvc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] robot_x;
  logic signed [POS_W-1:0] robot_y;
  logic signed [ANG_W-1:0] robot_heading;
  logic signed [POS_W-1:0] goal_x;
  logic signed [POS_W-1:0] goal_y;
  logic                    goal_present;

  modport source (
    output valid, robot_x, robot_y, robot_heading, goal_x, goal_y, goal_present,
    input  ready
  );

  modport sink (
    input  valid, robot_x, robot_y, robot_heading, goal_x, goal_y, goal_present,
    output ready
  );
endinterface

// ===== sv/ggvc_out_if.sv =====
interface ggvc_out_if import ggvc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] speed_cmd;
  logic signed [CMD_W-1:0] turn_rate_cmd;

  modport source (
    output valid, speed_cmd, turn_rate_cmd,
    input  ready
  );

  modport sink (
    input  valid, speed_cmd, turn_rate_cmd,
    output ready
  );
endinterface

// ===== sv/ggvc_front.sv =====
module ggvc_front import ggvc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [POS_W-1:0] robot_x_i,
  input  logic signed [POS_W-1:0] robot_y_i,
  input  logic signed [ANG_W-1:0] robot_heading_i,
  input  logic signed [POS_W-1:0] goal_x_i,
  input  logic signed [POS_W-1:0] goal_y_i,
  input  logic                    goal_present_i,
  output ctl_t                    ctl_o,
  output logic signed [XY_W-1:0]  x_o,
  output logic signed [XY_W-1:0]  y_o,
  output logic signed [Z_W-1:0]   z_o,
  output logic signed [ANG_W-1:0] heading_o
);

  ctl_t                     diff_ctl_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [ANG_W-1:0]  diff_hd_q;

  ctl_t                     rot_ctl_d, rot_ctl_q;
  logic signed [XY_W-1:0]   x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]    z_d, z_q;
  logic signed [ANG_W-1:0]  rot_hd_q;

  logic signed [DIFF_W-1:0] dx_d, dy_d;
  logic signed [XY_W-1:0]   xe, ye;

  assign dx_d = DIFF_W'(goal_x_i) - DIFF_W'(robot_x_i);
  assign dy_d = DIFF_W'(goal_y_i) - DIFF_W'(robot_y_i);

  // Move the vector into the right half plane; the angle starts at 0, or at +pi or -pi when it is turned over
  always_comb begin
    xe = XY_W'(dx_q) <<< FRAC_SHIFT;
    ye = XY_W'(dy_q) <<< FRAC_SHIFT;
    rot_ctl_d      = diff_ctl_q;
    rot_ctl_d.zero = (dx_q == '0) && (dy_q == '0);
    if (dx_q[DIFF_W-1]) begin
      x_d = -xe;
      y_d = -ye;
      z_d = dy_q[DIFF_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x_d = xe;
      y_d = ye;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_ctl_q <= '0;
      rot_ctl_q  <= '0;
    end else if (en_i) begin
      diff_ctl_q <= '{valid: valid_i, present: goal_present_i, zero: 1'b0};
      rot_ctl_q  <= rot_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      diff_hd_q <= robot_heading_i;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      rot_hd_q  <= diff_hd_q;
    end
  end

  assign ctl_o     = rot_ctl_q;
  assign x_o       = x_q;
  assign y_o       = y_q;
  assign z_o       = z_q;
  assign heading_o = rot_hd_q;

endmodule

// ===== sv/ggvc_cordic.sv =====
module ggvc_cordic import ggvc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [XY_W-1:0]  y_i,
  input  logic signed [Z_W-1:0]   z_i,
  input  logic signed [ANG_W-1:0] heading_i,
  output ctl_t                    ctl_o,
  output logic signed [XY_W-1:0]  x_o,
  output logic signed [Z_W-1:0]   z_o,
  output logic signed [ANG_W-1:0] heading_o
);

  ctl_t                    ctl_q [CORDIC_STAGES];
  logic signed [XY_W-1:0]  x_q   [CORDIC_STAGES];
  logic signed [XY_W-1:0]  y_q   [CORDIC_STAGES];
  logic signed [Z_W-1:0]   z_q   [CORDIC_STAGES];
  logic signed [ANG_W-1:0] hd_q  [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    ctl_t                    ctl_in;
    logic signed [XY_W-1:0]  x_in, y_in, xs, ys, x_d, y_d;
    logic signed [Z_W-1:0]   z_in, z_d, ang;
    logic signed [ANG_W-1:0] hd_in;

    if (i == 0) begin : g_head
      assign ctl_in = ctl_i;
      assign x_in   = x_i;
      assign y_in   = y_i;
      assign z_in   = z_i;
      assign hd_in  = heading_i;
    end else begin : g_tail
      assign ctl_in = ctl_q[i-1];
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign hd_in  = hd_q[i-1];
    end

    // Rotate towards the x axis by the stage's elementary angle
    always_comb begin
      ang = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_Q30[i]});
      xs  = x_in >>> i;
      ys  = y_in >>> i;
      if (!y_in[XY_W-1]) begin
        x_d = x_in + ys;
        y_d = y_in - xs;
        z_d = z_in + ang;
      end else begin
        x_d = x_in - ys;
        y_d = y_in + xs;
        z_d = z_in - ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]  <= x_d;
        y_q[i]  <= y_d;
        z_q[i]  <= z_d;
        hd_q[i] <= hd_in;
      end
    end
  end

  assign ctl_o     = ctl_q[CORDIC_STAGES-1];
  assign x_o       = x_q[CORDIC_STAGES-1];
  assign z_o       = z_q[CORDIC_STAGES-1];
  assign heading_o = hd_q[CORDIC_STAGES-1];

endmodule

// ===== sv/ggvc_cmd.sv =====
module ggvc_cmd import ggvc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [Z_W-1:0]   z_i,
  input  logic signed [ANG_W-1:0] heading_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  output logic signed [CMD_W-1:0] speed_o,
  output logic signed [CMD_W-1:0] turn_rate_o
);

  // Stage 1: partial products of the speed gain, raw heading error
  ctl_t                     mul_ctl_q;
  logic signed [PLO_W-1:0]  p_lo_d, p_lo_q;
  logic signed [PHI_W-1:0]  p_hi_d, p_hi_q;
  logic signed [Z_W-1:0]    err_d, err_q;
  logic signed [XS_W-1:0]   xsh;
  logic signed [Z_W-1:0]    z_eff;
  logic signed [SPLIT:0]    lo_part;
  logic signed [XS_W-SPLIT-1:0] hi_part;

  always_comb begin
    xsh     = ctl_i.zero ? '0 : XS_W'(x_i >>> FRAC_SHIFT);
    z_eff   = ctl_i.zero ? '0 : z_i;
    lo_part = $signed({1'b0, xsh[SPLIT-1:0]});
    hi_part = xsh[XS_W-1:SPLIT];
    p_lo_d  = lo_part * SPEED_GAIN;
    p_hi_d  = hi_part * SPEED_GAIN;
    err_d   = z_eff - (Z_W'(heading_i) <<< HD_SHIFT);
  end

  // Stage 2: combine the products, wrap the error into [-pi, pi]
  ctl_t                     sum_ctl_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [Z_W-1:0]    werr_d, werr_q;

  always_comb begin
    prod_d = (PROD_W'(p_hi_q) <<< SPLIT) + PROD_W'(p_lo_q);
    if (err_q > PI_Q30) begin
      werr_d = err_q - TWO_PI_Q30;
    end else if (err_q < -PI_Q30) begin
      werr_d = err_q + TWO_PI_Q30;
    end else begin
      werr_d = err_q;
    end
  end

  // Stage 3: round half up and saturate
  ctl_t                     rnd_ctl_q;
  logic signed [PROD_W-1:0] spd_full;
  logic signed [SAT_W-1:0]  trn_full;
  logic signed [CMD_W-1:0]  spd_sat_d, spd_sat_q, trn_sat_d, trn_sat_q;

  always_comb begin
    spd_full  = (prod_q + (PROD_W'(1) <<< (SPD_SHIFT - 1))) >>> SPD_SHIFT;
    trn_full  = (SAT_W'(werr_q) * SAT_W'(3) + (SAT_W'(1) <<< (TRN_SHIFT - 1))) >>> TRN_SHIFT;
    spd_sat_d = sat_cmd(SAT_W'(spd_full));
    trn_sat_d = sat_cmd(trn_full);
  end

  // Stage 4: clamp to the configured limits, or force zero without a goal, into the output register
  logic                    out_valid_q;
  logic signed [CMD_W-1:0] speed_d, speed_q, turn_d, turn_q;

  always_comb begin
    if (rnd_ctl_q.present) begin
      speed_d = clamp_cmd(spd_sat_q, cfg_i.speed_min, cfg_i.speed_max);
      turn_d  = clamp_cmd(trn_sat_q, cfg_i.turn_rate_min, cfg_i.turn_rate_max);
    end else begin
      speed_d = '0;
      turn_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ctl_q   <= '0;
      sum_ctl_q   <= '0;
      rnd_ctl_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_ctl_q   <= ctl_i;
      sum_ctl_q   <= mul_ctl_q;
      rnd_ctl_q   <= sum_ctl_q;
      out_valid_q <= rnd_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_lo_q    <= p_lo_d;
      p_hi_q    <= p_hi_d;
      err_q     <= err_d;
      prod_q    <= prod_d;
      werr_q    <= werr_d;
      spd_sat_q <= spd_sat_d;
      trn_sat_q <= trn_sat_d;
      speed_q   <= speed_d;
      turn_q    <= turn_d;
    end
  end

  assign valid_o     = out_valid_q;
  assign speed_o     = speed_q;
  assign turn_rate_o = turn_q;

endmodule

// ===== sv/go_to_goal_velocity_controller.sv =====
// Channel   Dir   Handshake      Payload
// in_ch     in    valid/ready    robot_x, robot_y, robot_heading, goal_x, goal_y, goal_present
// out_ch    out   valid/ready    speed_cmd, turn_rate_cmd
// cfg       in    cfg_we_i       cfg_idx_i selects the limit, cfg_wdata_i carries it
//
// One transaction is taken every cycle while out_ch is not stalled; the pipeline has
// two front stages, one CORDIC stage per iteration and four command stages.
// The speed gain product is split into two partial products over the first command stage.
// A stall on out_ch freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits and loads the default limits; there is no clearing pass.
module go_to_goal_velocity_controller import ggvc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ggvc_in_if.sink                 in_ch,
  ggvc_out_if.source              out_ch,
  input  logic                    cfg_we_i,
  input  cfg_idx_t                cfg_idx_i,
  input  logic signed [CMD_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic pipe_en;
  logic out_valid;

  // Advance while the output register is empty or being taken
  assign pipe_en     = !out_valid || out_ch.ready;
  assign in_ch.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_min     <= SPEED_MIN_RST;
      cfg_q.speed_max     <= SPEED_MAX_RST;
      cfg_q.turn_rate_min <= TURN_RATE_MIN_RST;
      cfg_q.turn_rate_max <= TURN_RATE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED_MIN:     cfg_q.speed_min     <= cfg_wdata_i;
        CFG_SPEED_MAX:     cfg_q.speed_max     <= cfg_wdata_i;
        CFG_TURN_RATE_MIN: cfg_q.turn_rate_min <= cfg_wdata_i;
        CFG_TURN_RATE_MAX: cfg_q.turn_rate_max <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ctl_t                    front_ctl;
  logic signed [XY_W-1:0]  front_x, front_y;
  logic signed [Z_W-1:0]   front_z;
  logic signed [ANG_W-1:0] front_hd;

  ggvc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (pipe_en),
    .valid_i         (in_ch.valid),
    .robot_x_i       (in_ch.robot_x),
    .robot_y_i       (in_ch.robot_y),
    .robot_heading_i (in_ch.robot_heading),
    .goal_x_i        (in_ch.goal_x),
    .goal_y_i        (in_ch.goal_y),
    .goal_present_i  (in_ch.goal_present),
    .ctl_o           (front_ctl),
    .x_o             (front_x),
    .y_o             (front_y),
    .z_o             (front_z),
    .heading_o       (front_hd)
  );

  ctl_t                    cordic_ctl;
  logic signed [XY_W-1:0]  cordic_x;
  logic signed [Z_W-1:0]   cordic_z;
  logic signed [ANG_W-1:0] cordic_hd;

  ggvc_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .ctl_i     (front_ctl),
    .x_i       (front_x),
    .y_i       (front_y),
    .z_i       (front_z),
    .heading_i (front_hd),
    .ctl_o     (cordic_ctl),
    .x_o       (cordic_x),
    .z_o       (cordic_z),
    .heading_o (cordic_hd)
  );

  ggvc_cmd u_cmd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .ctl_i       (cordic_ctl),
    .x_i         (cordic_x),
    .z_i         (cordic_z),
    .heading_i   (cordic_hd),
    .cfg_i       (cfg_q),
    .valid_o     (out_valid),
    .speed_o     (out_ch.speed_cmd),
    .turn_rate_o (out_ch.turn_rate_cmd)
  );

  assign out_ch.valid = out_valid;

  // A stalled pipeline holds the CORDIC result in place
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(cordic_ctl))
    else $error("CORDIC stage moved during a stall");

  // The vector is rotated from the right half plane, so x never turns negative
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_ctl.valid |-> !cordic_x[XY_W-1])
    else $error("CORDIC magnitude went negative");

  // Hold a waiting result and its payload until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.speed_cmd) &&
                                      $stable(out_ch.turn_rate_cmd))
    else $error("waiting result changed before it was taken");

endmodule
